FILE: sv/mwsc_pkg.sv
// ----------------------------------------------------------------------------
// mwsc_pkg: shared types and constants for the mecanum wheel speed commander
// Field widths, arithmetic widths, register indexes and the command/status
// structs between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package mwsc_pkg;

  // Payload and register widths
  localparam int VEL_W      = 20;
  localparam int YAW_W      = 22;
  localparam int GAIN_W     = 24;
  localparam int ARM_W      = 16;
  localparam int TICK_W     = 16;
  localparam int ID_W       = 8;
  localparam int CAN_ID_W   = 29;
  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int NUM_WHEELS = 4;

  // Arithmetic widths: velocities are Q16, the bracket is Q32
  localparam int LIN_SHIFT  = 16;
  localparam int TURN_W     = ARM_W + 1 + YAW_W;       // signed arm * yaw
  localparam int BRK_W      = TURN_W + 1;              // sum of three terms
  localparam int MAG_W      = BRK_W - 1;
  localparam int MAG_LO_W   = 20;
  localparam int MAG_HI_W   = MAG_W - MAG_LO_W;
  localparam int PLO_W      = MAG_LO_W + GAIN_W;
  localparam int PHI_W      = MAG_HI_W + GAIN_W;
  localparam int PROD_W     = MAG_W + GAIN_W;
  localparam int FRAC_SHIFT = 40;                      // Q32 * Q8
  localparam int SPD_W      = PROD_W - FRAC_SHIFT;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  // Frame id: wheel id with the set-speed packet kind above it
  localparam int                  KIND_SHIFT            = 8;
  localparam logic [CAN_ID_W-1:0] PACKET_KIND_SET_SPEED = CAN_ID_W'(3);

  localparam logic ACTION_CMD  = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ERPM_GAIN      = 3'd0,
    REG_ARM_LENGTH     = 3'd1,
    REG_TIMEOUT_TICKS  = 3'd2,
    REG_SEND_PERIOD    = 3'd3,
    REG_ID_FRONT_LEFT  = 3'd4,
    REG_ID_FRONT_RIGHT = 3'd5,
    REG_ID_REAR_LEFT   = 3'd6,
    REG_ID_REAR_RIGHT  = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    WHEEL_FL = 2'd0,
    WHEEL_FR = 2'd1,
    WHEEL_RL = 2'd2,
    WHEEL_RR = 2'd3
  } wheel_e;

  typedef struct packed {
    logic   turn_en;
    logic   brk_en;
    logic   abs_en;
    logic   mul_en;
    logic   fin_en;
    wheel_e wheel;
  } dp_cmd_t;

  typedef struct packed {
    logic burst;
    logic out_free;
  } dp_status_t;

endpackage

FILE: sv/mecanum_wheel_speed_commander.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_commander: four-wheel mecanum inverse kinematics
// Turns body velocity commands and 1 ms ticks into bursts of four wheel
// speed frames (front-left, front-right, rear-left, rear-right).
// ----------------------------------------------------------------------------
// A velocity command leaves the input ready, and so does a tick that does
// not end the send period. A tick that ends the period starts a burst: the
// arm * yaw product first, then for each wheel the bracket sum, magnitude,
// split multiply by the gain and finish steps through a single shared
// datapath; the finish step waits while the output register holds a beat
// that is not taken. The input is not ready again until the fourth beat
// sits in the output register; that beat may still wait there while new items come in.
// Speeds are zero once the command is timeout_ticks old or older.
module mecanum_wheel_speed_commander (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mwsc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [mwsc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   action_i,
  input  logic signed [mwsc_pkg::VEL_W-1:0]      vx_i,
  input  logic signed [mwsc_pkg::VEL_W-1:0]      vy_i,
  input  logic signed [mwsc_pkg::YAW_W-1:0]      yaw_rate_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [mwsc_pkg::CAN_ID_W-1:0]          can_id_o,
  output logic [mwsc_pkg::DATA_W-1:0]            data_word_o,
  output logic                                   last_o
);
  import mwsc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  mwsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  mwsc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_fire_i   (in_fire),
    .action_i    (action_i),
    .vx_i        (vx_i),
    .vy_i        (vy_i),
    .yaw_rate_i  (yaw_rate_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .can_id_o    (can_id_o),
    .data_word_o (data_word_o),
    .last_o      (last_o)
  );

endmodule

FILE: sv/mwsc_ctrl.sv
// ----------------------------------------------------------------------------
// mwsc_ctrl: burst sequencer
// Walks the four wheels through bracket, magnitude, multiply and finish steps
// after a tick that ends a send period.
// ----------------------------------------------------------------------------
module mwsc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_fire_i,
  input  mwsc_pkg::dp_status_t status_i,
  output logic                in_ready_o,
  output mwsc_pkg::dp_cmd_t   cmd_o
);
  import mwsc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TURN,
    S_BRK,
    S_ABS,
    S_MUL,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  wheel_e wheel_q, wheel_d;

  always_comb begin
    state_d = state_q;
    wheel_d = wheel_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire_i && status_i.burst) begin
          state_d = S_TURN;
          wheel_d = WHEEL_FL;
        end
      end
      S_TURN: state_d = S_BRK;
      S_BRK:  state_d = S_ABS;
      S_ABS:  state_d = S_MUL;
      S_MUL:  state_d = S_FIN;
      S_FIN: begin
        // hold until the output register can take the beat
        if (status_i.out_free) begin
          if (wheel_q == WHEEL_RR) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_BRK;
            wheel_d = wheel_e'(wheel_q + 2'd1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wheel_q <= WHEEL_FL;
    end else begin
      state_q <= state_d;
      wheel_q <= wheel_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign cmd_o.turn_en = (state_q == S_TURN);
  assign cmd_o.brk_en  = (state_q == S_BRK);
  assign cmd_o.abs_en  = (state_q == S_ABS);
  assign cmd_o.mul_en  = (state_q == S_MUL);
  assign cmd_o.fin_en  = (state_q == S_FIN) && status_i.out_free;
  assign cmd_o.wheel   = wheel_q;

endmodule

FILE: sv/mwsc_datapath.sv
// ----------------------------------------------------------------------------
// mwsc_datapath: command store, tick counters and wheel speed arithmetic
// Holds configuration, the last command and its age, and computes one wheel
// speed at a time through a split multiplier into the output register.
// ----------------------------------------------------------------------------
module mwsc_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mwsc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [mwsc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   in_fire_i,
  input  logic                                   action_i,
  input  logic signed [mwsc_pkg::VEL_W-1:0]      vx_i,
  input  logic signed [mwsc_pkg::VEL_W-1:0]      vy_i,
  input  logic signed [mwsc_pkg::YAW_W-1:0]      yaw_rate_i,
  input  mwsc_pkg::dp_cmd_t                      cmd_i,
  output mwsc_pkg::dp_status_t                   status_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [mwsc_pkg::CAN_ID_W-1:0]          can_id_o,
  output logic [mwsc_pkg::DATA_W-1:0]            data_word_o,
  output logic                                   last_o
);
  import mwsc_pkg::*;

  // Configuration
  logic [GAIN_W-1:0] gain_q;
  logic [ARM_W-1:0]  arm_q;
  logic [TICK_W-1:0] timeout_q;
  logic [TICK_W-1:0] period_cfg_q;
  logic [ID_W-1:0]   id_q [NUM_WHEELS];

  // Command state
  logic signed [VEL_W-1:0] held_vx_q, held_vy_q;
  logic signed [YAW_W-1:0] held_yaw_q;
  logic [TICK_W-1:0]       age_q, period_q;
  logic [TICK_W-1:0]       age_inc, period_inc;
  logic                    active_q;
  logic                    tick_fire;

  // Arithmetic pipeline
  logic signed [TURN_W-1:0] turn_q;
  logic signed [BRK_W-1:0]  brk_q;
  logic signed [BRK_W-1:0]  lin_x, lin_y, turn_ext, y_term, t_term;
  logic [MAG_W-1:0]         mag_q;
  logic                     neg_q;
  logic [PLO_W-1:0]         plo_q;
  logic [PHI_W-1:0]         phi_q;
  logic [PROD_W-1:0]        prod;
  logic [SPD_W-1:0]         spd;
  logic                     sub_y, sub_t, negate;

  // Output register
  logic                out_valid_q;
  logic [CAN_ID_W-1:0] can_id_q;
  logic [DATA_W-1:0]   data_q;
  logic                last_q;

  assign tick_fire  = in_fire_i && (action_i == ACTION_TICK);
  assign age_inc    = (age_q == TICK_MAX) ? age_q : age_q + 1'b1;
  assign period_inc = (period_q == TICK_MAX) ? period_q : period_q + 1'b1;

  assign status_o.burst    = tick_fire && (period_inc >= period_cfg_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q       <= GAIN_W'(830592);
      arm_q        <= ARM_W'(24248);
      timeout_q    <= TICK_W'(1000);
      period_cfg_q <= TICK_W'(25);
      id_q[0]      <= ID_W'(71);
      id_q[1]      <= ID_W'(73);
      id_q[2]      <= ID_W'(72);
      id_q[3]      <= ID_W'(74);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ERPM_GAIN:      gain_q       <= cfg_data_i[GAIN_W-1:0];
        REG_ARM_LENGTH:     arm_q        <= cfg_data_i[ARM_W-1:0];
        REG_TIMEOUT_TICKS:  timeout_q    <= cfg_data_i[TICK_W-1:0];
        REG_SEND_PERIOD:    period_cfg_q <= cfg_data_i[TICK_W-1:0];
        REG_ID_FRONT_LEFT:  id_q[0]      <= cfg_data_i[ID_W-1:0];
        REG_ID_FRONT_RIGHT: id_q[1]      <= cfg_data_i[ID_W-1:0];
        REG_ID_REAR_LEFT:   id_q[2]      <= cfg_data_i[ID_W-1:0];
        REG_ID_REAR_RIGHT:  id_q[3]      <= cfg_data_i[ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_vx_q  <= '0;
      held_vy_q  <= '0;
      held_yaw_q <= '0;
      age_q      <= '0;
      period_q   <= '0;
      active_q   <= 1'b0;
    end else if (in_fire_i) begin
      if (action_i == ACTION_CMD) begin
        held_vx_q  <= vx_i;
        held_vy_q  <= vy_i;
        held_yaw_q <= yaw_rate_i;
        age_q      <= '0;
      end else begin
        age_q    <= age_inc;
        period_q <= status_o.burst ? '0 : period_inc;
        active_q <= age_inc < timeout_q;
      end
    end
  end

  // Wheel signs: front-left x-y-t, front-right x+y+t, rear-left x+y-t,
  // rear-right x-y+t; left wheels negated afterwards.
  assign sub_y  = (cmd_i.wheel == WHEEL_FL) || (cmd_i.wheel == WHEEL_RR);
  assign sub_t  = (cmd_i.wheel == WHEEL_FL) || (cmd_i.wheel == WHEEL_RL);
  assign negate = sub_t;

  assign lin_x    = BRK_W'($signed({held_vx_q, LIN_SHIFT'(0)}));
  assign lin_y    = BRK_W'($signed({held_vy_q, LIN_SHIFT'(0)}));
  assign turn_ext = BRK_W'(turn_q);
  assign y_term   = sub_y ? -lin_y : lin_y;
  assign t_term   = sub_t ? -turn_ext : turn_ext;

  // Magnitude is split so each partial product stays within 20x24 bits
  assign prod = (PROD_W'(phi_q) << MAG_LO_W) + PROD_W'(plo_q);
  assign spd  = prod[PROD_W-1:FRAC_SHIFT];

  always_ff @(posedge clk_i) begin
    if (cmd_i.turn_en) begin
      turn_q <= TURN_W'($signed({1'b0, arm_q})) * TURN_W'(held_yaw_q);
    end
    if (cmd_i.brk_en) begin
      brk_q <= lin_x + y_term + t_term;
    end
    if (cmd_i.abs_en) begin
      neg_q <= brk_q[BRK_W-1] ^ negate;
      // drop to zero once the command has timed out
      if (!active_q) begin
        mag_q <= '0;
      end else if (brk_q[BRK_W-1]) begin
        mag_q <= MAG_W'(-brk_q);
      end else begin
        mag_q <= MAG_W'(brk_q);
      end
    end
    if (cmd_i.mul_en) begin
      plo_q <= PLO_W'(mag_q[MAG_LO_W-1:0]) * PLO_W'(gain_q);
      phi_q <= PHI_W'(mag_q[MAG_W-1:MAG_LO_W]) * PHI_W'(gain_q);
    end
    // speed magnitude stays below 2^22, so the int32 clamp never engages
    if (cmd_i.fin_en) begin
      can_id_q <= (PACKET_KIND_SET_SPEED << KIND_SHIFT) | CAN_ID_W'(id_q[cmd_i.wheel]);
      data_q   <= neg_q ? -DATA_W'(spd) : DATA_W'(spd);
      last_q   <= (cmd_i.wheel == WHEEL_RR);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign can_id_o    = can_id_q;
  assign data_word_o = data_q;
  assign last_o      = last_q;

endmodule

FILE: sv/mwsc_checker.sv
// ----------------------------------------------------------------------------
// mwsc_checker: port-level checks for the wheel speed commander
// Watches the top-level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module mwsc_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_ready_o,
  input logic                                   action_i,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic [mwsc_pkg::CAN_ID_W-1:0]          can_id_o,
  input logic [mwsc_pkg::DATA_W-1:0]            data_word_o,
  input logic                                   last_o
);
  import mwsc_pkg::*;

  // a stalled beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(can_id_o)
      && $stable(data_word_o) && $stable(last_o))
    else $error("output beat changed while stalled");

  // a command never starts a burst
  a_cmd_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ACTION_CMD) |=> in_ready_o)
    else $error("input stalled after a command");

  // every frame carries the set-speed packet kind
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (can_id_o >> KIND_SHIFT) == PACKET_KIND_SET_SPEED)
    else $error("frame id lacks set-speed kind");

  // while idle only the closing beat of a burst can be waiting
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> last_o)
    else $error("input ready with a burst unfinished");

endmodule

bind mecanum_wheel_speed_commander mwsc_checker u_mwsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .can_id_o    (can_id_o),
  .data_word_o (data_word_o),
  .last_o      (last_o)
);

FILE: bench/tb_mecanum_wheel_speed_commander.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mecanum_wheel_speed_commander: self-checking bench for the speed commander
// Feeds velocity commands and ticks through a valid/ready driver. Random idle
// gaps and output stalls are applied. Each tick is predicted here in fixed
// point. Every speed frame is compared with the oldest predicted frame.
// Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_mecanum_wheel_speed_commander;
  import mwsc_pkg::*;

  localparam int STALL_LIMIT   = 2000;  // cycles without any beat
  localparam int SETTLE_CYCLES = 24;    // quiet time once all frames are out
  localparam longint ERPM_MAX  = 2147483647;
  localparam longint ERPM_MIN  = -ERPM_MAX - 1;

  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic signed [YAW_W-1:0] YAW_MAX = {1'b0, {(YAW_W-1){1'b1}}};
  localparam logic signed [YAW_W-1:0] YAW_MIN = {1'b1, {(YAW_W-1){1'b0}}};

  typedef struct {
    logic                    action;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic signed [YAW_W-1:0] yaw;
  } body_item_t;

  typedef struct {
    logic [CAN_ID_W-1:0] can_id;
    logic [DATA_W-1:0]   data_word;
    logic                last;
  } speed_frame_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  cfg_reg_e                       cfg_idx_i   = REG_ERPM_GAIN;
  logic        [CFG_DATA_W-1:0]   cfg_data_i  = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  logic                           action_i    = ACTION_TICK;
  logic signed [VEL_W-1:0]        vx_i        = '0;
  logic signed [VEL_W-1:0]        vy_i        = '0;
  logic signed [YAW_W-1:0]        yaw_rate_i  = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic        [CAN_ID_W-1:0]     can_id_o;
  logic        [DATA_W-1:0]       data_word_o;
  logic                           last_o;

  // Register copies, at their reset values
  logic [GAIN_W-1:0] gain_cfg    = 24'd830592;
  logic [ARM_W-1:0]  arm_cfg     = 16'd24248;
  logic [TICK_W-1:0] timeout_cfg = 16'd1000;
  logic [TICK_W-1:0] period_cfg  = 16'd25;
  logic [ID_W-1:0]   wheel_id_cfg [NUM_WHEELS] = '{8'd71, 8'd73, 8'd72, 8'd74};

  // Held command and counters
  logic signed [VEL_W-1:0] held_vx    = '0;
  logic signed [VEL_W-1:0] held_vy    = '0;
  logic signed [YAW_W-1:0] held_yaw   = '0;
  logic [TICK_W-1:0]       cmd_age    = '0;
  logic [TICK_W-1:0]       period_cnt = '0;

  body_item_t   body_items[$];
  speed_frame_t wheel_frames_due[$];
  body_item_t   next_item;
  speed_frame_t due;
  logic         in_fire      = 1'b0;
  logic         steady_feed  = 1'b0;
  int           gap_left     = 0;
  int           stall_left   = 0;
  int           idle_cycles  = 0;
  int           mismatches   = 0;

  mecanum_wheel_speed_commander u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .vx_i       (vx_i),
    .vy_i       (vy_i),
    .yaw_rate_i (yaw_rate_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .can_id_o   (can_id_o),
    .data_word_o(data_word_o),
    .last_o     (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Bracket is Q32, gain Q8: truncate the magnitude, restore the sign, apply the negate flag and clamp to int32
  function automatic longint wheel_erpm(input longint bracket, input bit negate);
    longint unsigned mag;
    longint          speed;
    mag   = (bracket < 0) ? -bracket : bracket;
    mag   = (mag * gain_cfg) >> FRAC_SHIFT;
    speed = (bracket < 0) ? -longint'(mag) : longint'(mag);
    if (negate) speed = -speed;
    if (speed > ERPM_MAX) speed = ERPM_MAX;
    if (speed < ERPM_MIN) speed = ERPM_MIN;
    return speed;
  endfunction

  task automatic predict_wheel_frames(input logic action,
                                      input logic signed [VEL_W-1:0] vx,
                                      input logic signed [VEL_W-1:0] vy,
                                      input logic signed [YAW_W-1:0] yaw);
    longint       lin_x;
    longint       lin_y;
    longint       turn;
    longint       erpm [NUM_WHEELS];
    speed_frame_t frame;
    if (action == ACTION_CMD) begin
      held_vx  = vx;
      held_vy  = vy;
      held_yaw = yaw;
      cmd_age  = '0;
      return;
    end
    if (cmd_age != TICK_MAX) cmd_age++;
    if (period_cnt != TICK_MAX) period_cnt++;
    if (period_cnt < period_cfg) return;
    period_cnt = '0;

    lin_x = longint'(held_vx) <<< LIN_SHIFT;
    lin_y = longint'(held_vy) <<< LIN_SHIFT;
    turn  = longint'(arm_cfg) * longint'(held_yaw);
    if (cmd_age < timeout_cfg) begin
      erpm[WHEEL_FL] = wheel_erpm(lin_x - lin_y - turn, 1'b1);
      erpm[WHEEL_FR] = wheel_erpm(lin_x + lin_y + turn, 1'b0);
      erpm[WHEEL_RL] = wheel_erpm(lin_x + lin_y - turn, 1'b1);
      erpm[WHEEL_RR] = wheel_erpm(lin_x - lin_y + turn, 1'b0);
    end else begin
      erpm = '{default: 0};
    end
    for (int w = 0; w < NUM_WHEELS; w++) begin
      frame.can_id    = CAN_ID_W'(wheel_id_cfg[w]) | (PACKET_KIND_SET_SPEED << KIND_SHIFT);
      frame.data_word = erpm[w][DATA_W-1:0];
      frame.last      = (w == NUM_WHEELS - 1);
      wheel_frames_due.push_back(frame);
    end
  endtask

  function automatic void push_item(input logic action,
                                    input logic signed [VEL_W-1:0] vx,
                                    input logic signed [VEL_W-1:0] vy,
                                    input logic signed [YAW_W-1:0] yaw);
    body_item_t it;
    it.action = action;
    it.vx     = vx;
    it.vy     = vy;
    it.yaw    = yaw;
    body_items.push_back(it);
  endfunction

  // Ticks carry random payload as well; the block must ignore it
  function automatic void push_random(input int cmd_pct);
    push_item(($urandom_range(0, 99) < cmd_pct) ? ACTION_CMD : ACTION_TICK,
              VEL_W'($urandom), VEL_W'($urandom), YAW_W'($urandom));
  endfunction

  // Block is idle here, so the register copy may change at once
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      REG_ERPM_GAIN:      gain_cfg               = value;
      REG_ARM_LENGTH:     arm_cfg                = value[ARM_W-1:0];
      REG_TIMEOUT_TICKS:  timeout_cfg            = value[TICK_W-1:0];
      REG_SEND_PERIOD:    period_cfg             = value[TICK_W-1:0];
      REG_ID_FRONT_LEFT:  wheel_id_cfg[WHEEL_FL] = value[ID_W-1:0];
      REG_ID_FRONT_RIGHT: wheel_id_cfg[WHEEL_FR] = value[ID_W-1:0];
      REG_ID_REAR_LEFT:   wheel_id_cfg[WHEEL_RL] = value[ID_W-1:0];
      default:            wheel_id_cfg[WHEEL_RR] = value[ID_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every item is in and every frame is out, then let the block go quiet
  task automatic settle();
    while (body_items.size() != 0 || in_valid_i || wheel_frames_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (in_valid_i) gap_left = steady_feed ? 0 : draw_gap();
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (body_items.size() != 0) begin
        next_item = body_items.pop_front();
        in_valid_i <= 1'b1;
        action_i   <= next_item.action;
        vx_i       <= next_item.vx;
        vy_i       <= next_item.vy;
        yaw_rate_i <= next_item.yaw;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 99) < 20) stall_left = draw_gap();
    end
  end

  // Monitor: predict on each input beat, check each output beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o)
        predict_wheel_frames(action_i, vx_i, vy_i, yaw_rate_i);
      if (out_valid_o && out_ready_i) begin
        if (wheel_frames_due.size() == 0) begin
          $error("unexpected frame: can_id %0h data_word %0h last %0b",
                 can_id_o, data_word_o, last_o);
          mismatches++;
        end else begin
          due = wheel_frames_due.pop_front();
          if (can_id_o !== due.can_id) begin
            $error("can_id: expected %0h, actual %0h", due.can_id, can_id_o);
            mismatches++;
          end
          if (data_word_o !== due.data_word) begin
            $error("data_word: expected %0h, actual %0h", due.data_word, data_word_o);
            mismatches++;
          end
          if (last_o !== due.last) begin
            $error("last: expected %0b, actual %0b", due.last, last_o);
            mismatches++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset register values; no command yet, so the first burst is all zero
    repeat (25) push_random(0);
    repeat (40) push_random(20);
    settle();

    // Widest gain and arm, a burst on every tick, field extremes
    write_reg(REG_ERPM_GAIN, 24'hFFFFFF);
    write_reg(REG_ARM_LENGTH, 24'h00FFFF);
    write_reg(REG_TIMEOUT_TICKS, 24'h00FFFF);
    write_reg(REG_SEND_PERIOD, 24'h000001);
    write_reg(REG_ID_FRONT_LEFT, 24'h000000);
    write_reg(REG_ID_FRONT_RIGHT, 24'h0000FF);
    write_reg(REG_ID_REAR_LEFT, 24'h0000A5);
    write_reg(REG_ID_REAR_RIGHT, 24'h00005A);
    push_item(ACTION_CMD, VEL_MAX, VEL_MAX, YAW_MAX);
    push_item(ACTION_TICK, '0, '0, '0);
    push_item(ACTION_CMD, VEL_MIN, VEL_MIN, YAW_MIN);
    push_item(ACTION_TICK, '0, '0, '0);
    push_item(ACTION_CMD, VEL_MAX, VEL_MIN, YAW_MIN);
    push_item(ACTION_TICK, '0, '0, '0);
    push_item(ACTION_CMD, VEL_MIN, VEL_MAX, YAW_MAX);
    push_item(ACTION_TICK, '0, '0, '0);
    push_item(ACTION_CMD, VEL_MAX, VEL_MAX, YAW_MIN);
    push_item(ACTION_TICK, '0, '0, '0);
    push_item(ACTION_CMD, '0, '0, '0);
    push_item(ACTION_TICK, '0, '0, '0);
    push_item(ACTION_CMD, -20'sd1, 20'sd1, -22'sd1);
    push_item(ACTION_TICK, '0, '0, '0);
    settle();

    // Zero timeout and zero period: every tick bursts, all speeds zero
    write_reg(REG_TIMEOUT_TICKS, 24'h000000);
    write_reg(REG_SEND_PERIOD, 24'h000000);
    write_reg(REG_ARM_LENGTH, 24'h000000);
    write_reg(REG_ERPM_GAIN, 24'h000100);
    write_reg(REG_ID_FRONT_LEFT, 24'h0000FF);
    write_reg(REG_ID_FRONT_RIGHT, 24'h000000);
    write_reg(REG_ID_REAR_LEFT, 24'h0000FF);
    write_reg(REG_ID_REAR_RIGHT, 24'h000000);
    push_item(ACTION_CMD, VEL_MAX, VEL_MIN, YAW_MAX);
    push_item(ACTION_TICK, '0, '0, '0);
    push_item(ACTION_TICK, '0, '0, '0);
    settle();

    // Timeout boundary: live on the first tick, zero on the second
    write_reg(REG_TIMEOUT_TICKS, 24'h000002);
    push_item(ACTION_CMD, 20'sd65536, -20'sd32768, 22'sd1000);
    push_item(ACTION_TICK, '0, '0, '0);
    push_item(ACTION_TICK, '0, '0, '0);
    settle();

    for (int p = 0; p < 4; p++) begin
      write_reg(REG_ERPM_GAIN, (p == 0) ? 24'h000000 : (p == 1) ? 24'hFFFFFF
                                                     : CFG_DATA_W'($urandom));
      write_reg(REG_ARM_LENGTH, (p == 1) ? 24'h000000 : CFG_DATA_W'($urandom));
      write_reg(REG_TIMEOUT_TICKS, {8'($urandom), 16'($urandom_range(1, 12))});
      write_reg(REG_SEND_PERIOD, {8'($urandom), 16'($urandom_range(0, 3))});
      write_reg(REG_ID_FRONT_LEFT, CFG_DATA_W'($urandom));
      write_reg(REG_ID_FRONT_RIGHT, CFG_DATA_W'($urandom));
      write_reg(REG_ID_REAR_LEFT, CFG_DATA_W'($urandom));
      write_reg(REG_ID_REAR_RIGHT, CFG_DATA_W'($urandom));
      repeat (34) push_random(30);
      settle();
    end

    // Back-to-back feed with a short timeout, so speeds drop to zero mid-run
    write_reg(REG_ERPM_GAIN, CFG_DATA_W'($urandom_range(1, 16777215)));
    write_reg(REG_ARM_LENGTH, CFG_DATA_W'($urandom));
    write_reg(REG_TIMEOUT_TICKS, 24'h000003);
    write_reg(REG_SEND_PERIOD, 24'h000002);
    steady_feed = 1'b1;
    push_item(ACTION_CMD, VEL_MAX, 20'sd1000, YAW_MIN);
    repeat (8) push_item(ACTION_TICK, '0, '0, '0);
    settle();
    steady_feed = 1'b0;

    if (mismatches == 0 && wheel_frames_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
